// ----- design/proximity_dedup_filter_defines.svh -----
// proximity_dedup_filter_defines.svh
// assertion macros used by proximity_dedup_filter.sv, no other dependencies
`ifndef PROXIMITY_DEDUP_FILTER_DEFINES_SVH
`define PROXIMITY_DEDUP_FILTER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PDF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("proximity_dedup_filter: assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define PDF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("proximity_dedup_filter: assertion failed");

`endif

// ----- design/pdf_pkg.sv -----
// pdf_pkg.sv
// types and constants of the proximity de-duplication filter, no dependencies
package pdf_pkg;

    localparam int POS_W   = 24;
    localparam int THR_W   = 24;
    localparam int TAG_W   = 16;
    localparam int SLOT_W  = 6;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_X_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_THRESHOLD = 2'd1;

    typedef struct packed {
        logic                    frame_start;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [TAG_W-1:0]        obstacle_id;
    } pdf_in_t;

    typedef struct packed {
        logic              kept;
        logic              overflow;
        logic [SLOT_W-1:0] slot;
        logic [TAG_W-1:0]  tag_out;
    } pdf_out_t;

    // request travelling down the cell chain
    typedef struct packed {
        logic                    valid;
        logic                    frame_start;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [TAG_W-1:0]        tag;
        logic                    hit;
        logic                    stored;
        logic [SLOT_W-1:0]       slot;
        logic [SLOT_W-1:0]       idx;
    } pdf_tok_t;

    // exact magnitude of a - b
    function automatic logic [POS_W:0] abs_diff(input logic signed [POS_W-1:0] a,
                                                input logic signed [POS_W-1:0] b);
        logic signed [POS_W:0] d;
        begin
            d = {a[POS_W-1], a} - {b[POS_W-1], b};
            abs_diff = d[POS_W] ? (POS_W+1)'(0) - d : d;
        end
    endfunction

endpackage

// ----- design/proximity_dedup_filter.sv -----
// proximity_dedup_filter.sv
// top level: config registers, chain of pdf_cell entries, result register
// depends on pdf_pkg, pdf_cell and proximity_dedup_filter_defines.svh
//
//  channel   handshake            payload             direction
//  in        in_valid / in_stall  in_data  (pdf_in_t)  request in
//  out       out_valid/ out_stall out_data (pdf_out_t) result out
//  cfg       cfg_valid/ cfg_ready cfg_index, cfg_data  register write in
//
// one request enters per cycle while in_stall is low; each request walks the cell
// chain one entry per cycle while it advances, into the result register at its tail
// reset clears thresholds, entry occupancy and all valid flags; entry positions
// are only loaded on store and need no reset
// a stalled result freezes the whole chain, and in_stall follows in the same cycle
// cfg_ready is always high
module proximity_dedup_filter #(
    parameter int MAX_KEPT = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  pdf_pkg::pdf_in_t                in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output pdf_pkg::pdf_out_t               out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pdf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pdf_pkg::THR_W-1:0]       cfg_data
);
    import pdf_pkg::*;

    `include "proximity_dedup_filter_defines.svh"

    logic [THR_W-1:0] x_thr_reg, x_thr_next;
    logic [THR_W-1:0] y_thr_reg, y_thr_next;
    logic             out_valid_reg, out_valid_next;
    pdf_out_t         out_data_reg, out_data_next;
    logic             advance;
    pdf_tok_t         head_tok;
    pdf_tok_t         chain [0:MAX_KEPT];

    // chain moves whenever the result register can take what falls off its end
    assign advance   = ~out_valid_reg | ~out_stall;
    assign in_stall  = ~advance;
    assign cfg_ready = 1'b1;

    // threshold registers
    always_comb
    begin
        x_thr_next = x_thr_reg;
        y_thr_next = y_thr_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_X_THRESHOLD: x_thr_next = cfg_data;
                REG_Y_THRESHOLD: y_thr_next = cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_thr_reg <= '0;
            y_thr_reg <= '0;
        end
        else
        begin
            x_thr_reg <= x_thr_next;
            y_thr_reg <= y_thr_next;
        end
    end

    // head of the chain: fresh request, nothing found, nothing stored yet
    always_comb
    begin
        head_tok             = '0;
        head_tok.valid       = in_valid;
        head_tok.frame_start = in_data.frame_start;
        head_tok.pos_x       = in_data.pos_x;
        head_tok.pos_y       = in_data.pos_y;
        head_tok.tag         = in_data.obstacle_id;
    end

    assign chain[0] = head_tok;

    // one cell per table entry; entries fill from the head, so the first free
    // cell a non-overlapping request meets is the next slot of the frame
    genvar k;
    generate
        for (k = 0; k < MAX_KEPT; k++)
        begin : g_cell
            pdf_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .advance (advance),
                .x_thr   (x_thr_reg),
                .y_thr   (y_thr_reg),
                .tok_in  (chain[k]),
                .tok_out (chain[k+1])
            );
        end
    endgenerate

    // result register at the tail: no hit and no store means the table was full
    always_comb
    begin
        out_valid_next         = chain[MAX_KEPT].valid;
        out_data_next.kept     = chain[MAX_KEPT].stored;
        out_data_next.overflow = ~chain[MAX_KEPT].hit & ~chain[MAX_KEPT].stored;
        out_data_next.slot     = chain[MAX_KEPT].slot;
        out_data_next.tag_out  = chain[MAX_KEPT].tag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // a result is never both stored and an overflow
    `PDF_ASSERT_IMP(a_kept_xor_ovf, out_valid_reg, !(out_data_reg.kept && out_data_reg.overflow))
    // slot stays zero unless the obstacle was stored
    `PDF_ASSERT_IMP(a_slot_zero, out_valid_reg && !out_data_reg.kept, out_data_reg.slot == '0)
    // a frame start always lands in the first entry
    `PDF_ASSERT_IMP(a_fs_slot0, chain[1].valid && chain[1].frame_start, chain[1].stored && chain[1].slot == '0)
    // an accepted request shows up in the first cell on the next edge
    `PDF_ASSERT_NEXT(a_head_load, in_valid && !in_stall, chain[1].valid)

endmodule

// ----- design/pdf_cell.sv -----
// pdf_cell.sv
// one table entry of the filter: compare, store on first free cell, pass request on
// depends on pdf_pkg
module pdf_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic [pdf_pkg::THR_W-1:0]   x_thr,
    input  logic [pdf_pkg::THR_W-1:0]   y_thr,
    input  pdf_pkg::pdf_tok_t           tok_in,
    output pdf_pkg::pdf_tok_t           tok_out
);
    import pdf_pkg::*;

    logic                    occ_reg, occ_next;
    logic signed [POS_W-1:0] x_reg, x_next;
    logic signed [POS_W-1:0] y_reg, y_next;
    pdf_tok_t                tok_reg, tok_next;
    logic [POS_W:0]          dx, dy;
    logic                    occ_now, hit_here, store_here;

    always_comb
    begin
        // a frame start empties the entry before this request looks at it
        occ_now    = occ_reg & ~tok_in.frame_start;
        dx         = abs_diff(x_reg, tok_in.pos_x);
        dy         = abs_diff(y_reg, tok_in.pos_y);
        hit_here   = tok_in.valid & occ_now & (dx < {1'b0, x_thr}) & (dy < {1'b0, y_thr});
        store_here = tok_in.valid & ~tok_in.hit & ~tok_in.stored & ~occ_now;

        occ_next = occ_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        if (tok_in.valid)
        begin
            occ_next = occ_now | store_here;
        end
        if (store_here)
        begin
            x_next = tok_in.pos_x;
            y_next = tok_in.pos_y;
        end

        tok_next        = tok_in;
        tok_next.hit    = tok_in.hit | hit_here;
        tok_next.stored = tok_in.stored | store_here;
        tok_next.slot   = store_here ? tok_in.idx : tok_in.slot;
        tok_next.idx    = tok_in.idx + SLOT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
            tok_reg <= '0;
        end
        else if (advance)
        begin
            occ_reg <= occ_next;
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    assign tok_out = tok_reg;

endmodule
